// ----- rtl/mvm4_pkg.sv -----
`default_nettype none

package mvm4_pkg;

    // Element and accumulator widths
    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int PAIR_W    = PROD_W + 1;
    localparam int SUM_W     = PROD_W + 2;
    localparam int DIM       = 4;

    // Configuration register file
    localparam int NUM_REGS  = 8;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_ROW0_LEFT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW0_RIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1_LEFT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1_RIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROW2_LEFT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROW2_RIGHT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ROW3_LEFT  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ROW3_RIGHT = 3'd7;

    // Identity matrix: 1.0 in the low or high half of a row register
    localparam logic [CFG_W-1:0] ONE_LOW  = 64'h0000_0000_0001_0000;
    localparam logic [CFG_W-1:0] ONE_HIGH = 64'h0001_0000_0000_0000;

    // Saturation limits
    localparam logic [DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

    typedef logic signed [DATA_W-1:0] t_elem;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [PAIR_W-1:0] t_pair;
    typedef logic signed [SUM_W-1:0]  t_sum;

endpackage

`default_nettype wire

// ----- rtl/matrix4_vector_multiply.sv -----
// Matrix 4x4 times column vector, signed Q16.16.
//
// Input channel (i_valid / o_ready) carries one column x, y, z, w per request.
// Output channel (o_valid / i_ready) returns the product column and a clipped
// flag that is set when any element saturated to the signed 32-bit range.
// Each element is the exact sum of four 64-bit products, shifted right by 16
// (toward minus infinity) and saturated.
// The matrix lives in eight 64-bit row registers written through i_cfg_we,
// i_cfg_idx and i_cfg_data; write them only while the pipeline is empty.
// A request accepted at one edge loads its products at that edge, then
// passes the pair add, the row add and the saturate into the output
// register; a stall can hold it in any stage.
// Throughput: one request per cycle while the receiver does not stall; the 16
// parallel multipliers and the four register stages set that figure.
// Reset clears all stage valid bits and loads the identity matrix.
// When the receiver stalls, each stage holds until the next one frees up;
// bubbles are squeezed out, so o_ready only falls once all four stages are
// full, and nothing is dropped or repeated.
`default_nettype none

module matrix4_vector_multiply (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    // configuration
    input  wire                             i_cfg_we,
    input  wire [mvm4_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire [mvm4_pkg::CFG_W-1:0]       i_cfg_data,
    // input column
    input  wire                             i_valid,
    output logic                            o_ready,
    input  wire signed [mvm4_pkg::DATA_W-1:0] i_x_in,
    input  wire signed [mvm4_pkg::DATA_W-1:0] i_y_in,
    input  wire signed [mvm4_pkg::DATA_W-1:0] i_z_in,
    input  wire signed [mvm4_pkg::DATA_W-1:0] i_w_in,
    // result column
    output logic                            o_valid,
    input  wire                             i_ready,
    output logic signed [mvm4_pkg::DATA_W-1:0] o_x_out,
    output logic signed [mvm4_pkg::DATA_W-1:0] o_y_out,
    output logic signed [mvm4_pkg::DATA_W-1:0] o_z_out,
    output logic signed [mvm4_pkg::DATA_W-1:0] o_w_out,
    output logic                            o_clipped
);

    import mvm4_pkg::*;

    localparam int TOP_W = SUM_W - FRAC_BITS - DATA_W + 1;

    logic [CFG_W-1:0] r_cfg [NUM_REGS];

    t_elem vec [DIM];
    t_elem mat [DIM][DIM];

    t_prod r_prod [DIM][DIM];
    t_pair r_pair [DIM][2];
    t_sum  r_sum  [DIM];
    logic [DATA_W-1:0] r_out [DIM];
    logic [DATA_W-1:0] n_out [DIM];
    logic              r_clip;
    logic              n_clip;
    logic [TOP_W-1:0]  top_bits [DIM];
    logic              fits [DIM];

    logic r_v1, r_v2, r_v3, r_v4;
    logic en1, en2, en3, en4;

    // Stage enables: a stage loads when empty or when its successor moves
    assign en4 = !r_v4 || i_ready;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;

    assign o_ready = en1;
    assign o_valid = r_v4;

    // Write the row registers, reset to identity
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[REG_ROW0_LEFT]  <= ONE_LOW;
            r_cfg[REG_ROW0_RIGHT] <= '0;
            r_cfg[REG_ROW1_LEFT]  <= ONE_HIGH;
            r_cfg[REG_ROW1_RIGHT] <= '0;
            r_cfg[REG_ROW2_LEFT]  <= '0;
            r_cfg[REG_ROW2_RIGHT] <= ONE_LOW;
            r_cfg[REG_ROW3_LEFT]  <= '0;
            r_cfg[REG_ROW3_RIGHT] <= ONE_HIGH;
        end else if (i_cfg_we) begin
            r_cfg[i_cfg_idx] <= i_cfg_data;
        end
    end

    // Unpack matrix elements and the input column
    assign vec[0] = i_x_in;
    assign vec[1] = i_y_in;
    assign vec[2] = i_z_in;
    assign vec[3] = i_w_in;

    always_comb begin
        for (int r = 0; r < DIM; r++) begin
            for (int c = 0; c < DIM; c++) begin
                mat[r][c] = r_cfg[2 * r + c / 2][DATA_W * (c % 2) +: DATA_W];
            end
        end
    end

    // Advance the valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
        end
    end

    // Stage 1: sixteen products
    always_ff @(posedge i_clk) begin
        if (en1 && i_valid) begin
            for (int r = 0; r < DIM; r++) begin
                for (int c = 0; c < DIM; c++) begin
                    r_prod[r][c] <= mat[r][c] * vec[c];
                end
            end
        end
    end

    // Stage 2: add products in pairs
    always_ff @(posedge i_clk) begin
        if (en2 && r_v1) begin
            for (int r = 0; r < DIM; r++) begin
                for (int h = 0; h < 2; h++) begin
                    r_pair[r][h] <= {r_prod[r][2*h][PROD_W-1], r_prod[r][2*h]}
                                  + {r_prod[r][2*h+1][PROD_W-1], r_prod[r][2*h+1]};
                end
            end
        end
    end

    // Stage 3: full row sums
    always_ff @(posedge i_clk) begin
        if (en3 && r_v2) begin
            for (int r = 0; r < DIM; r++) begin
                r_sum[r] <= {r_pair[r][0][PAIR_W-1], r_pair[r][0]}
                          + {r_pair[r][1][PAIR_W-1], r_pair[r][1]};
            end
        end
    end

    // Drop the fraction bits and saturate to 32 bits
    always_comb begin
        n_clip = 1'b0;
        for (int r = 0; r < DIM; r++) begin
            top_bits[r] = r_sum[r][SUM_W-1 -: TOP_W];
            fits[r]     = (&top_bits[r]) || !(|top_bits[r]);
            if (fits[r]) begin
                n_out[r] = r_sum[r][FRAC_BITS +: DATA_W];
            end else if (r_sum[r][SUM_W-1]) begin
                n_out[r] = SAT_MIN;
            end else begin
                n_out[r] = SAT_MAX;
            end
            n_clip = n_clip || !fits[r];
        end
    end

    // Stage 4: output register
    always_ff @(posedge i_clk) begin
        if (en4 && r_v3) begin
            for (int r = 0; r < DIM; r++) begin
                r_out[r] <= n_out[r];
            end
            r_clip <= n_clip;
        end
    end

    assign o_x_out   = r_out[0];
    assign o_y_out   = r_out[1];
    assign o_z_out   = r_out[2];
    assign o_w_out   = r_out[3];
    assign o_clipped = r_clip;

`ifndef ASSERT_OFF
    // A clipped result carries at least one saturated element
    a_clip_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_clipped |->
            o_x_out == SAT_MAX || o_x_out == SAT_MIN ||
            o_y_out == SAT_MAX || o_y_out == SAT_MIN ||
            o_z_out == SAT_MAX || o_z_out == SAT_MIN ||
            o_w_out == SAT_MAX || o_w_out == SAT_MIN)
        else $error("clipped set without a saturated element");

    // An accepted request occupies the first stage next cycle
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> r_v1)
        else $error("accepted request lost at stage 1");

    // A stalled result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_x_out) && $stable(o_clipped))
        else $error("stalled result changed");

    // Reset empties the pipeline
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !r_v1)
        else $error("pipeline not empty after reset");
`endif

endmodule

`default_nettype wire
